@@ rtl/ppe_pkg.sv @@
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types and constants of the packed palette expander.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int BYTE_W      = 8;
  localparam int CODE_W      = 2;
  localparam int MODE_W      = 2;
  localparam int COUNT_W     = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int ENTRY_W     = 32;

  localparam logic OP_PAL_WR = 1'b0;
  localparam logic OP_UNPACK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd1;

  localparam logic [CODE_W-1:0] BITS_1 = 2'd0;
  localparam logic [CODE_W-1:0] BITS_2 = 2'd1;
  localparam logic [CODE_W-1:0] BITS_4 = 2'd2;
  localparam logic [CODE_W-1:0] BITS_8 = 2'd3;

  localparam logic [MODE_W-1:0] MODE_INDEX = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RGB   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RGBA  = 2'd2;

  typedef struct packed {
    logic pal_wr;
    logic load;
    logic fetch;
    logic advance;
  } ppe_cmd_t;

  typedef struct packed {
    logic is_unpack;
    logic has_pixels;
    logic last;
  } ppe_sts_t;

endpackage

@@ rtl/ppe_if.sv @@
// ----------------------------------------------------------------------------
// ppe_if
// Channel interfaces of the packed palette expander: input items, result
// items and configuration writes.
// ----------------------------------------------------------------------------
interface ppe_in_if;
  import ppe_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [BYTE_W-1:0]    pal_index;
  logic [BYTE_W-1:0]    pal_red;
  logic [BYTE_W-1:0]    pal_green;
  logic [BYTE_W-1:0]    pal_blue;
  logic [BYTE_W-1:0]    pal_alpha;
  logic [BYTE_W-1:0]    src_byte;
  logic [COUNT_W-1:0]   pixel_count;

  modport source (output valid, opcode, pal_index, pal_red, pal_green, pal_blue,
                  pal_alpha, src_byte, pixel_count, input ready);
  modport sink   (input valid, opcode, pal_index, pal_red, pal_green, pal_blue,
                  pal_alpha, src_byte, pixel_count, output ready);
endinterface

interface ppe_out_if;
  import ppe_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_red;
  logic [BYTE_W-1:0] out_green;
  logic [BYTE_W-1:0] out_blue;
  logic [BYTE_W-1:0] out_alpha;
  logic              last_in_byte;

  modport source (output valid, out_red, out_green, out_blue, out_alpha,
                  last_in_byte, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha,
                  last_in_byte, output ready);
endinterface

interface ppe_cfg_if;
  import ppe_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/ppe_ram.sv @@
// ----------------------------------------------------------------------------
// ppe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ppe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/ppe_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppe_ctrl
// Controller of the packed palette expander: sequences the palette read and
// the result beat of each pixel taken from a source byte.
// ----------------------------------------------------------------------------
module ppe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ppe_pkg::ppe_sts_t sts,
  output ppe_pkg::ppe_cmd_t cmd
);
  import ppe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_OUT   = 3'b100
  } ppe_state_t;

  ppe_state_t state_r, state_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  assign cmd.pal_wr  = in_acc && !sts.is_unpack;
  assign cmd.load    = in_acc && sts.is_unpack && sts.has_pixels;
  assign cmd.fetch   = (state_r == S_FETCH);
  assign cmd.advance = out_acc;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          state_nxt = sts.last ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/ppe_dp.sv @@
// ----------------------------------------------------------------------------
// ppe_dp
// Datapath of the packed palette expander: configuration registers, source
// byte shifter, pixel counter, palette memory and result formatting.
// ----------------------------------------------------------------------------
module ppe_dp #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ppe_pkg::ppe_cmd_t                cmd,
  output ppe_pkg::ppe_sts_t                sts,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ppe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppe_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             opcode,
  input  logic [ppe_pkg::BYTE_W-1:0]       pal_index,
  input  logic [ppe_pkg::BYTE_W-1:0]       pal_red,
  input  logic [ppe_pkg::BYTE_W-1:0]       pal_green,
  input  logic [ppe_pkg::BYTE_W-1:0]       pal_blue,
  input  logic [ppe_pkg::BYTE_W-1:0]       pal_alpha,
  input  logic [ppe_pkg::BYTE_W-1:0]       src_byte,
  input  logic [ppe_pkg::COUNT_W-1:0]      pixel_count,
  output logic [ppe_pkg::BYTE_W-1:0]       out_red,
  output logic [ppe_pkg::BYTE_W-1:0]       out_green,
  output logic [ppe_pkg::BYTE_W-1:0]       out_blue,
  output logic [ppe_pkg::BYTE_W-1:0]       out_alpha,
  output logic                             last_in_byte
);
  import ppe_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [CODE_W-1:0]  code_r;
  logic [MODE_W-1:0]  mode_r;
  logic [BYTE_W-1:0]  src_r, src_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]  idx_r;
  logic               oob_r;
  logic [BYTE_W-1:0]  cur_idx;
  logic [BYTE_W-1:0]  src_shifted;
  logic [COUNT_W-1:0] per_byte;
  logic [COUNT_W-1:0] sat_count;
  logic               wr_in_range;
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= BITS_8;
      mode_r <= MODE_RGB;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BITS: code_r <= cfg_data[CODE_W-1:0];
        CFG_MODE: mode_r <= cfg_data[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (code_r)
      BITS_1: begin
        cur_idx     = {7'd0, src_r[7]};
        src_shifted = {src_r[6:0], 1'b0};
        per_byte    = 4'd8;
      end
      BITS_2: begin
        cur_idx     = {6'd0, src_r[7:6]};
        src_shifted = {src_r[5:0], 2'b00};
        per_byte    = 4'd4;
      end
      BITS_4: begin
        cur_idx     = {4'd0, src_r[7:4]};
        src_shifted = {src_r[3:0], 4'h0};
        per_byte    = 4'd2;
      end
      default: begin
        cur_idx     = src_r;
        src_shifted = 8'h00;
        per_byte    = 4'd1;
      end
    endcase
  end

  assign sat_count = (pixel_count > per_byte) ? per_byte : pixel_count;

  assign sts.is_unpack  = (opcode == OP_UNPACK);
  assign sts.has_pixels = (sat_count != '0);
  assign sts.last       = (cnt_r == COUNT_W'(1));

  always_comb begin
    src_nxt = src_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      src_nxt = src_byte;
      cnt_nxt = sat_count;
    end else if (cmd.advance) begin
      src_nxt = src_shifted;
      cnt_nxt = cnt_r - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    cnt_r <= cnt_nxt;
    if (cmd.fetch) begin
      idx_r <= cur_idx;
      oob_r <= ({1'b0, cur_idx} >= 9'(PALETTE_DEPTH));
    end
  end

  assign wr_in_range = ({1'b0, pal_index} < 9'(PALETTE_DEPTH));

  ppe_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (cmd.pal_wr && wr_in_range),
    .waddr(pal_index[AW-1:0]),
    .wdata({pal_alpha, pal_blue, pal_green, pal_red}),
    .re   (cmd.fetch),
    .raddr(cur_idx[AW-1:0]),
    .rdata(rdata)
  );

  assign entry = oob_r ? '0 : rdata;

  always_comb begin
    if (mode_r == MODE_INDEX) begin
      out_red   = idx_r;
      out_green = '0;
      out_blue  = '0;
      out_alpha = '0;
    end else begin
      out_red   = entry[7:0];
      out_green = entry[15:8];
      out_blue  = entry[23:16];
      out_alpha = (mode_r == MODE_RGBA) ? entry[31:24] : '0;
    end
  end

  assign last_in_byte = sts.last;

endmodule

@@ rtl/packed_palette_expand.sv @@
// ----------------------------------------------------------------------------
// packed_palette_expand
// Expands packed 1, 2, 4 or 8 bit pixel indices into raw index, RGB or RGBA
// results through a palette memory.
// ----------------------------------------------------------------------------
// A palette-write item is taken and produces no result. An unpack item is
// taken and then, for each pixel, the block does the registered palette read
// (S_FETCH) and then holds the result beat (S_OUT) until the sink takes it;
// the next item is taken after the last result beat. The palette memory
// holds PALETTE_DEPTH entries and an entry must be written before it is used.
module packed_palette_expand #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  ppe_in_if.sink   in_chan,
  ppe_out_if.source out_chan,
  ppe_cfg_if.sink  cfg_chan
);
  import ppe_pkg::*;

  ppe_cmd_t cmd;
  ppe_sts_t sts;

  ppe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .out_valid(out_chan.valid),
    .out_ready(out_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppe_dp #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_chan.valid),
    .cfg_ready   (cfg_chan.ready),
    .cfg_index   (cfg_chan.index),
    .cfg_data    (cfg_chan.data),
    .opcode      (in_chan.opcode),
    .pal_index   (in_chan.pal_index),
    .pal_red     (in_chan.pal_red),
    .pal_green   (in_chan.pal_green),
    .pal_blue    (in_chan.pal_blue),
    .pal_alpha   (in_chan.pal_alpha),
    .src_byte    (in_chan.src_byte),
    .pixel_count (in_chan.pixel_count),
    .out_red     (out_chan.out_red),
    .out_green   (out_chan.out_green),
    .out_blue    (out_chan.out_blue),
    .out_alpha   (out_chan.out_alpha),
    .last_in_byte(out_chan.last_in_byte)
  );

endmodule

@@ test/tb_packed_palette_expand.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packed_palette_expand
// Self-checking bench for the packed palette expander. A behavioral copy of
// the palette and the two registers predicts every pixel beat. Directed items
// cover the field extremes and corner cases. Random phases then sweep bit
// depths and output modes with random idling on both channels. A long output
// stall and a drain pause are exercised at the end.
// ----------------------------------------------------------------------------
module tb_packed_palette_expand;
  import ppe_pkg::*;

  localparam int PAL_DEPTH      = 256;
  localparam int SETTLE_CYCLES  = 20;
  localparam int PARK_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic               opcode;
    logic [BYTE_W-1:0]  pal_index;
    logic [BYTE_W-1:0]  red;
    logic [BYTE_W-1:0]  green;
    logic [BYTE_W-1:0]  blue;
    logic [BYTE_W-1:0]  alpha;
    logic [BYTE_W-1:0]  src;
    logic [COUNT_W-1:0] count;
  } pal_item_t;

  typedef struct {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic              last;
  } pixel_t;

  logic clk;
  logic rst_n;

  ppe_in_if  in_if ();
  ppe_out_if out_if ();
  ppe_cfg_if cfg_if ();

  packed_palette_expand #(.PALETTE_DEPTH(PAL_DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  logic [ENTRY_W-1:0] pal_shadow [PAL_DEPTH];
  bit                 pal_written [PAL_DEPTH];
  logic [CODE_W-1:0]  bits_code;
  logic [MODE_W-1:0]  mode_sel;

  pixel_t expected_pixels[$];

  int error_count;
  int items_sent;
  int palette_writes;
  int pixels_checked;
  int tx_idle_pct;
  int rx_idle_pct;
  bit park_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_written(int lim);
    int hits[$];
    for (int i = 0; i < lim; i++) begin
      if (pal_written[i]) hits.push_back(i);
    end
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(hits.size() - 1)];
  endfunction

  function automatic void expand_item(pal_item_t it);
    int width;
    int used;
    int idx;
    logic [ENTRY_W-1:0] entry;
    pixel_t px;
    if (it.opcode == OP_PAL_WR) begin
      pal_shadow[it.pal_index] = {it.alpha, it.blue, it.green, it.red};
      pal_written[it.pal_index] = 1'b1;
      palette_writes++;
    end else begin
      width = 1 << bits_code;
      used = (int'(it.count) > 8 / width) ? 8 / width : int'(it.count);
      for (int k = 0; k < used; k++) begin
        idx = (it.src >> (8 - width * (k + 1))) & ((1 << width) - 1);
        if (mode_sel == MODE_INDEX) begin
          px = '{red: BYTE_W'(idx), green: '0, blue: '0, alpha: '0, last: 1'b0};
        end else begin
          entry = (idx < PAL_DEPTH) ? pal_shadow[idx] : '0;
          px.red   = entry[7:0];
          px.green = entry[15:8];
          px.blue  = entry[23:16];
          px.alpha = (mode_sel == MODE_RGBA) ? entry[31:24] : '0;
        end
        px.last = (k == used - 1);
        expected_pixels.push_back(px);
      end
    end
  endfunction

  task automatic push_item(pal_item_t it);
    int gap;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.opcode      <= it.opcode;
    in_if.pal_index   <= it.pal_index;
    in_if.pal_red     <= it.red;
    in_if.pal_green   <= it.green;
    in_if.pal_blue    <= it.blue;
    in_if.pal_alpha   <= it.alpha;
    in_if.src_byte    <= it.src;
    in_if.pixel_count <= it.count;
    in_if.valid       <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    expand_item(it);
    items_sent++;
  endtask

  task automatic send_palette(int idx, logic [ENTRY_W-1:0] word);
    pal_item_t it;
    it = '{opcode: OP_PAL_WR, pal_index: BYTE_W'(idx), red: word[7:0],
           green: word[15:8], blue: word[23:16], alpha: word[31:24],
           src: BYTE_W'($urandom), count: COUNT_W'($urandom)};
    push_item(it);
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] src, logic [COUNT_W-1:0] cnt);
    pal_item_t it;
    it = '{opcode: OP_UNPACK, pal_index: BYTE_W'($urandom), red: BYTE_W'($urandom),
           green: BYTE_W'($urandom), blue: BYTE_W'($urandom),
           alpha: BYTE_W'($urandom), src: src, count: cnt};
    push_item(it);
  endtask

  // Fields that the palette will be asked for point at entries already loaded.
  task automatic send_random_byte(logic [COUNT_W-1:0] cnt);
    int width;
    int used;
    int pick;
    int shamt;
    logic [BYTE_W-1:0] src;
    width = 1 << bits_code;
    used = (int'(cnt) > 8 / width) ? 8 / width : int'(cnt);
    src = BYTE_W'($urandom);
    if (mode_sel != MODE_INDEX) begin
      for (int k = 0; k < used; k++) begin
        pick = pick_written(1 << width);
        if (pick < 0) begin
          pick = $urandom_range((1 << width) - 1);
          send_palette(pick, $urandom);
        end
        shamt = 8 - width * (k + 1);
        src = BYTE_W'((int'(src) & ~(((1 << width) - 1) << shamt)) | (pick << shamt));
      end
    end
    send_byte(src, cnt);
  endtask

  task automatic send_random();
    int r;
    logic [COUNT_W-1:0] cnt;
    if ($urandom_range(99) < 25) begin
      send_palette($urandom_range(PAL_DEPTH - 1), $urandom);
    end else begin
      r = $urandom_range(9);
      if (r == 0) cnt = '0;
      else if (r == 1) cnt = COUNT_W'($urandom_range(9, 15));
      else cnt = COUNT_W'($urandom_range(1, 8));
      send_random_byte(cnt);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == CFG_BITS) bits_code = value[CODE_W-1:0];
    else if (idx == CFG_MODE) mode_sel = value[MODE_W-1:0];
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(logic [CODE_W-1:0] code, logic [MODE_W-1:0] mode);
    set_reg(CFG_BITS, CFG_DATA_W'(code));
    set_reg(CFG_MODE, CFG_DATA_W'(mode));
  endtask

  task automatic test_directed();
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_palette(0, 32'h00FF00FF);
    send_palette(1, 32'hFF00FF00);
    send_palette(2, 32'h01EFCDAB);
    send_palette(3, 32'h78563412);
    send_palette(15, 32'h80808080);
    send_palette(255, 32'hFFFFFFFF);
    send_byte(8'h00, 4'd1);
    send_byte(8'hFF, 4'd15);
    send_byte(8'h03, 4'd0);
    send_byte(8'h0F, 4'd1);
    set_reg(CFG_MODE, CFG_DATA_W'(MODE_RGBA));
    send_byte(8'hFF, 4'd1);
    send_byte(8'h02, 4'd1);
    set_reg(CFG_MODE, CFG_DATA_W'(MODE_SPARE));
    send_byte(8'h03, 4'd1);
    set_config(BITS_1, MODE_INDEX);
    send_byte(8'hA5, 4'd15);
    send_byte(8'h5A, 4'd3);
    set_reg(CFG_BITS, CFG_DATA_W'(BITS_2));
    send_byte(8'h1B, 4'd4);
    set_reg(CFG_BITS, CFG_DATA_W'(BITS_4));
    send_byte(8'hF0, 4'd2);
    set_reg(CFG_BITS, CFG_DATA_W'(BITS_8));
    send_byte(8'hFF, 4'd1);
    set_config(BITS_1, MODE_RGBA);
    send_byte(8'h5A, 4'd8);
    set_config(BITS_2, MODE_RGB);
    send_byte(8'hE4, 4'd4);
    set_config(BITS_4, MODE_RGBA);
    send_byte(8'hF0, 4'd2);
    set_reg(CFG_MODE, CFG_DATA_W'(MODE_SPARE));
    send_byte(8'h0F, 4'd9);
  endtask

  task automatic test_config_sweep();
    logic [CODE_W-1:0] codes [6] = '{BITS_1, BITS_8, BITS_1, BITS_8, BITS_2, BITS_4};
    logic [MODE_W-1:0] modes [6] = '{MODE_INDEX, MODE_SPARE, MODE_RGBA, MODE_INDEX,
                                     MODE_RGB, MODE_RGBA};
    int pcts [3] = '{0, 15, 40};
    for (int p = 0; p < 12; p++) begin
      if (p < 6) set_config(codes[p], modes[p]);
      else set_config(CODE_W'($urandom_range(3)), MODE_W'($urandom_range(3)));
      tx_idle_pct = pcts[$urandom_range(2)];
      rx_idle_pct = pcts[$urandom_range(2)];
      repeat (30) send_random();
    end
  endtask

  task automatic test_output_backpressure();
    set_config(BITS_1, MODE_RGBA);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    park_req = 1'b1;
    repeat (40) send_random_byte(4'd8);
  endtask

  task automatic test_drain_pause();
    set_config(BITS_2, MODE_INDEX);
    tx_idle_pct = 15;
    rx_idle_pct = 40;
    repeat (20) send_random();
    settle();
    repeat (20) send_random();
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_PAL_WR;
    in_if.pal_index = '0;
    in_if.pal_red = '0;
    in_if.pal_green = '0;
    in_if.pal_blue = '0;
    in_if.pal_alpha = '0;
    in_if.src_byte = '0;
    in_if.pixel_count = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_BITS;
    cfg_if.data = '0;
    bits_code = BITS_8;
    mode_sel = MODE_RGB;
    park_req = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    error_count = 0;
    items_sent = 0;
    palette_writes = 0;
    pixels_checked = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_config_sweep();
    test_output_backpressure();
    test_drain_pause();

    settle();
    if (expected_pixels.size() != 0) error_count++;
    $display("Sent %0d items (%0d palette loads) and checked %0d pixel beats",
             items_sent, palette_writes, pixels_checked);
    $display("over all bit depths and output modes, with stalls on both sides.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (park_req) begin
        park_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (PARK_CYCLES) @(negedge clk);
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap(rx_idle_pct);
      end
    end
  end

  task automatic note_error(string what, pixel_t want, pixel_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected r=%h g=%h b=%h a=%h last=%b, got r=%h g=%h b=%h a=%h last=%b",
               $realtime, what, want.red, want.green, want.blue, want.alpha, want.last,
               got.red, got.green, got.blue, got.alpha, got.last);
    end
  endtask

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{red: out_if.out_red, green: out_if.out_green, blue: out_if.out_blue,
              alpha: out_if.out_alpha, last: out_if.last_in_byte};
      if (expected_pixels.size() == 0) begin
        note_error("beat with nothing pending", got, got);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.last !== want.last) begin
          note_error("pixel mismatch", want, got);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog expired with %0d pixel beats pending.", expected_pixels.size());
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ppe_pkg.sv
rtl/ppe_if.sv
rtl/ppe_ram.sv
rtl/ppe_ctrl.sv
rtl/ppe_dp.sv
rtl/packed_palette_expand.sv
test/tb_packed_palette_expand.sv
